/* sv/u2j_pkg.sv */
// Shared types, character constants and helpers of the UTF-8 to JSON escaper.
package u2j_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_CHAR = 3'd1,
    K_ESC  = 3'd2,
    K_HEX1 = 3'd3,
    K_HEX2 = 3'd4
  } kind_t;

  typedef struct packed {
    logic        open;
    logic        close;
    kind_t       kind;
    logic [7:0]  ch;
    logic [15:0] hex_a;
    logic [15:0] hex_b;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else r = 8'h57 + {4'd0, n};
    return r;
  endfunction

  function automatic logic [3:0] body_len(input kind_t k);
    logic [3:0] r;
    case (k)
      K_CHAR:  r = 4'd1;
      K_ESC:   r = 4'd2;
      K_HEX1:  r = 4'd6;
      K_HEX2:  r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/u2j_front.sv */
// Front end: UTF-8 decoder that classifies each byte and turns code points and string boundaries into jobs.
module u2j_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      byte_value,
  input  logic            byte_present,
  input  logic            first_of_string,
  input  logic            last_of_string,
  output logic            job_push,
  output u2j_pkg::job_t   job
);
  import u2j_pkg::*;

  logic [20:0] partial_code, partial_code_next;
  logic [1:0]  bytes_pending, bytes_pending_next;

  logic        emit;
  logic [20:0] code;
  logic [20:0] s;

  always_comb begin
    logic consumed;
    partial_code_next  = partial_code;
    bytes_pending_next = bytes_pending;
    emit     = 1'b0;
    code     = '0;
    consumed = 1'b0;
    if (first_of_string) begin
      partial_code_next  = '0;
      bytes_pending_next = '0;
    end
    if (byte_present) begin
      if (bytes_pending_next != 2'd0) begin
        if (byte_value[7:6] == 2'b10) begin
          partial_code_next  = {partial_code_next[14:0], byte_value[5:0]};
          bytes_pending_next = bytes_pending_next - 2'd1;
          if (bytes_pending_next == 2'd0) begin
            emit = 1'b1;
            code = partial_code_next;
            partial_code_next = '0;
          end
          consumed = 1'b1;
        end else begin
          partial_code_next  = '0;
          bytes_pending_next = '0;
        end
      end
      if (!consumed) begin
        if (!byte_value[7]) begin
          emit = 1'b1;
          code = {13'd0, byte_value};
        end else if (byte_value[7:5] == 3'b110) begin
          partial_code_next  = {16'd0, byte_value[4:0]};
          bytes_pending_next = 2'd1;
        end else if (byte_value[7:4] == 4'b1110) begin
          partial_code_next  = {17'd0, byte_value[3:0]};
          bytes_pending_next = 2'd2;
        end else if (byte_value[7:3] == 5'b11110) begin
          partial_code_next  = {18'd0, byte_value[2:0]};
          bytes_pending_next = 2'd3;
        end
      end
    end
    if (last_of_string) begin
      partial_code_next  = '0;
      bytes_pending_next = '0;
    end
  end

  assign s = code - 21'h010000;

  always_comb begin
    job.open  = first_of_string;
    job.close = last_of_string;
    job.kind  = K_NONE;
    job.ch    = code[7:0];
    job.hex_a = code[15:0];
    job.hex_b = 16'({5'd0, s[9:0]} + 15'h5C00) | 16'h8000;
    if (emit) begin
      if (code == 21'h22 || code == 21'h5C) begin
        job.kind = K_ESC;
      end else if (code >= 21'h20 && code <= 21'h7E) begin
        job.kind = K_CHAR;
      end else if (code > 21'h00FFFF) begin
        job.kind  = K_HEX2;
        job.hex_a = 16'({5'd0, s[20:10]} + 16'hD800);
      end else begin
        job.kind = K_HEX1;
      end
    end
  end

  assign job_push = accept && (first_of_string || last_of_string || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code  <= '0;
      bytes_pending <= '0;
    end else if (accept) begin
      partial_code  <= partial_code_next;
      bytes_pending <= bytes_pending_next;
    end
  end

endmodule

/* sv/u2j_queue.sv */
// Short job queue between the decoder and the character sequencer.
module u2j_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u2j_pkg::job_t   wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output u2j_pkg::job_t   rd_job
);
  import u2j_pkg::*;

  job_t           mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;

  assign full     = (count == (QAw + 1)'(QDepth));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/u2j_back.sv */
// Back end: walks each job into the output register, one character per cycle while the output is not stalled.
module u2j_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  u2j_pkg::job_t   job,
  output logic            job_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_char,
  output logic            string_done,
  output logic            last_of_run
);
  import u2j_pkg::*;

  typedef enum logic [2:0] {
    S_OPEN  = 3'b001,
    S_BODY  = 3'b010,
    S_CLOSE = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] idx, idx_next;
  logic       out_valid;

  logic       advance;
  logic       done;
  logic [7:0] ch;
  logic       is_close;
  logic [3:0] len;

  assign len     = body_len(job.kind);
  assign advance = job_valid && (!out_valid || pop);
  assign job_pop = advance && done;
  assign empty   = !out_valid;

  always_comb begin
    logic        in_body;
    logic        hi_grp;
    logic [3:0]  pos;
    logic [15:0] v;
    in_body    = 1'b0;
    is_close   = 1'b0;
    done       = 1'b0;
    ch         = CH_QUOTE;
    phase_next = phase;
    idx_next   = idx;
    hi_grp     = (idx >= 4'd6);
    pos        = hi_grp ? idx - 4'd6 : idx;
    v          = hi_grp ? job.hex_b : job.hex_a;

    if (phase == S_OPEN && job.open) begin
      ch = CH_QUOTE;
      if (len != 4'd0) begin
        phase_next = S_BODY;
        idx_next   = '0;
      end else if (job.close) begin
        phase_next = S_CLOSE;
      end else begin
        done = 1'b1;
      end
    end else if ((phase == S_OPEN || phase == S_BODY) && len != 4'd0) begin
      in_body = 1'b1;
      if (idx + 4'd1 < len) begin
        phase_next = S_BODY;
        idx_next   = idx + 4'd1;
      end else if (job.close) begin
        phase_next = S_CLOSE;
      end else begin
        done = 1'b1;
      end
    end else begin
      is_close = 1'b1;
      done     = 1'b1;
    end

    if (in_body) begin
      case (job.kind)
        K_CHAR: ch = job.ch;
        K_ESC:  ch = (idx == 4'd0) ? CH_BSLASH : job.ch;
        default: begin
          case (pos)
            4'd0:    ch = CH_BSLASH;
            4'd1:    ch = CH_U;
            4'd2:    ch = hex_digit(v[15:12]);
            4'd3:    ch = hex_digit(v[11:8]);
            4'd4:    ch = hex_digit(v[7:4]);
            default: ch = hex_digit(v[3:0]);
          endcase
        end
      endcase
    end

    if (done) begin
      phase_next = S_OPEN;
      idx_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= S_OPEN;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase     <= phase_next;
        idx       <= idx_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char    <= ch;
      string_done <= is_close;
      last_of_run <= done;
    end
  end

endmodule

/* sv/utf8_to_json_string_escaper.sv */
// Top level: UTF-8 byte stream in, escaped JSON string characters out.
//
// Input queue side: present byte_value, byte_present, first_of_string and
// last_of_string with push; a word is taken on a clock edge with push high
// and full low. Output queue side: while empty is low, out_char,
// string_done and last_of_run hold the oldest character; pop takes it.
// A decoder classifies each byte in its accept cycle and hands any job to a
// four-entry queue; while the output is popped or empty, a sequencer emits
// one character per cycle from the head job into the output register. The
// first character of a word passes through the queue and then the output
// register. Unstalled, throughput is one output character per cycle: a
// byte giving one character sustains one word per cycle, an escape goes out
// one character at a time, and a byte giving no character pushes no job.
// When the receiver stalls, the output register holds, the queue fills and
// full rises after four pending jobs. Reset clears the decoder state, the
// queue and the valid flag of the output register.
module utf8_to_json_string_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_value,
  input  logic       byte_present,
  input  logic       first_of_string,
  input  logic       last_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       string_done,
  output logic       last_of_run
);
  import u2j_pkg::*;

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  logic job_pop;
  job_t job_head;

  assign accept = push && !full;

  u2j_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .byte_value      (byte_value),
    .byte_present    (byte_present),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .job_push        (job_push),
    .job             (job_in)
  );

  u2j_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (job_in),
    .full     (full),
    .rd_en    (job_pop),
    .rd_valid (job_valid),
    .rd_job   (job_head)
  );

  u2j_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job_head),
    .job_pop     (job_pop),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .string_done (string_done),
    .last_of_run (last_of_run)
  );

endmodule

/* test/utf8_to_json_string_escaper_tb.sv */
// Testbench for utf8_to_json_string_escaper: directed and random byte streams checked char by char.
module utf8_to_json_string_escaper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2j_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 150;
  localparam int TailCycles = 20;

  typedef struct {
    logic [7:0] ch;
    logic       done;
    logic       run_end;
  } json_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] byte_value = 8'h00;
  logic       byte_present = 1'b0;
  logic       first_of_string = 1'b0;
  logic       last_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       string_done;
  logic       last_of_run;

  json_char_t json_chars_due[$];
  logic [20:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;

  int  errors = 0;
  int  words_sent = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  utf8_to_json_string_escaper u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .byte_value      (byte_value),
    .byte_present    (byte_present),
    .first_of_string (first_of_string),
    .last_of_string  (last_of_string),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .string_done     (string_done),
    .last_of_run     (last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- escaping predictor ----------------

  function automatic void add_char(input logic [7:0] ch, input logic done);
    json_char_t t;
    t.ch = ch;
    t.done = done;
    t.run_end = 1'b0;
    json_chars_due.insert(json_chars_due.size(), t);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return 8'h61 + 8'(n - 4'd10);
  endfunction

  function automatic void add_hex4(input logic [15:0] v);
    add_char(CH_BSLASH, 1'b0);
    add_char(CH_U, 1'b0);
    add_char(hex_char(v[15:12]), 1'b0);
    add_char(hex_char(v[11:8]), 1'b0);
    add_char(hex_char(v[7:4]), 1'b0);
    add_char(hex_char(v[3:0]), 1'b0);
  endfunction

  function automatic void add_code(input logic [20:0] c);
    logic [20:0] s;
    if (c == 21'(CH_QUOTE)) begin
      add_char(CH_BSLASH, 1'b0);
      add_char(CH_QUOTE, 1'b0);
    end else if (c == 21'(CH_BSLASH)) begin
      add_char(CH_BSLASH, 1'b0);
      add_char(CH_BSLASH, 1'b0);
    end else if (c >= 21'h20 && c <= 21'h7E) begin
      add_char(c[7:0], 1'b0);
    end else if (c > 21'h00FFFF) begin
      s = c - 21'h010000;
      add_hex4({5'd0, s[20:10]} + 16'hD800);
      add_hex4({6'd0, s[9:0]} + 16'hDC00);
    end else begin
      add_hex4(c[15:0]);
    end
  endfunction

  function automatic void escape_word(input logic [7:0] b, input logic present,
                                      input logic is_first, input logic is_last);
    int start;
    logic taken;
    json_char_t t;
    start = json_chars_due.size();
    if (is_first) begin
      cp_acc = '0;
      cont_left = '0;
      add_char(CH_QUOTE, 1'b0);
    end
    if (present) begin
      taken = 1'b0;
      if (cont_left != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            add_code(cp_acc);
            cp_acc = '0;
          end
          taken = 1'b1;
        end else begin
          cp_acc = '0;
          cont_left = '0;
        end
      end
      if (!taken) begin
        if (!b[7]) begin
          add_code({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
          cp_acc = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          cp_acc = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end
      end
    end
    if (is_last) begin
      cp_acc = '0;
      cont_left = '0;
      add_char(CH_QUOTE, 1'b1);
    end
    if (json_chars_due.size() > start) begin
      t = json_chars_due[json_chars_due.size() - 1];
      t.run_end = 1'b1;
      json_chars_due[json_chars_due.size() - 1] = t;
    end
  endfunction

  // ---------------- driving ----------------

  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic present,
                           input logic is_first, input logic is_last);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    byte_value <= b;
    byte_present <= present;
    first_of_string <= is_first;
    last_of_string <= is_last;
    do @(posedge clk); while (full !== 1'b0);
    escape_word(b, present, is_first, is_last);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (json_chars_due.size() != 0);
  endtask

  // ---------------- result checking ----------------

  initial begin
    int gap;
    int hold_left;
    json_char_t want;
    gap = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (json_chars_due.size() == 0) begin
          $error("out_char: no character expected, got %h", out_char);
          errors++;
        end else begin
          want = json_chars_due.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            errors++;
          end
          if (string_done !== want.done) begin
            $error("string_done: expected %b, got %b", want.done, string_done);
            errors++;
          end
          if (last_of_run !== want.run_end) begin
            $error("last_of_run: expected %b, got %b", want.run_end, last_of_run);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        gap = pick_gap(recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("utf8_to_json_string_escaper verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_word(8'h00, 1'b0, 1'b1, 1'b1);   // empty string
    send_word(8'hA5, 1'b0, 1'b0, 1'b0);   // empty word, no output
    send_word(CH_QUOTE, 1'b1, 1'b1, 1'b0);
    send_word(CH_BSLASH, 1'b1, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0, 1'b0);
    send_word(8'hC0, 1'b1, 1'b0, 1'b0);   // overlong NUL
    send_word(8'h80, 1'b1, 1'b0, 1'b0);
    send_word(8'hE2, 1'b1, 1'b0, 1'b0);
    send_word(8'h82, 1'b1, 1'b0, 1'b0);
    send_word(8'hAC, 1'b1, 1'b0, 1'b0);
    send_word(8'hF7, 1'b1, 1'b0, 1'b0);   // beyond U+10FFFF
    send_word(8'hBF, 1'b1, 1'b0, 1'b0);
    send_word(8'hBF, 1'b1, 1'b0, 1'b0);
    send_word(8'hBF, 1'b1, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0, 1'b0);   // stray continuation
    send_word(8'hFF, 1'b1, 1'b0, 1'b0);   // invalid lead
    send_word(8'hE2, 1'b1, 1'b0, 1'b0);   // broken sequence
    send_word(8'h41, 1'b1, 1'b0, 1'b0);
    send_word(8'hF0, 1'b1, 1'b0, 1'b0);
    send_word(8'h9F, 1'b1, 1'b1, 1'b0);   // restart drops pending lead
    send_word(8'hF0, 1'b1, 1'b0, 1'b0);
    send_word(8'h9F, 1'b1, 1'b0, 1'b0);
    send_word(8'h98, 1'b1, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0, 1'b0);
    send_word(8'hC3, 1'b1, 1'b0, 1'b1);   // truncated at end of string
    wait_drained();
  endtask

  task automatic test_output_stall();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_word((i % 5 == 0) ? CH_QUOTE : 8'($urandom_range(0, 31)), 1'b1,
                i == 0, i == 29);
    end
    wait_drained();
  endtask

  task automatic send_random_string();
    logic [7:0] seq[$];
    int n_cp;
    int kind;
    logic [7:0] v;
    bit term;
    n_cp = $urandom_range(0, 6);
    for (int i = 0; i < n_cp; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        seq.insert(seq.size(), 8'($urandom_range(32, 126)));
      end else if (kind < 38) begin
        seq.insert(seq.size(), $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
      end else if (kind < 46) begin
        v = 8'($urandom_range(0, 32));
        seq.insert(seq.size(), v == 8'd32 ? 8'h7F : v);
      end else if (kind < 62) begin
        seq.insert(seq.size(), {3'b110, 5'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
      end else if (kind < 76) begin
        seq.insert(seq.size(), {4'b1110, 4'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
      end else if (kind < 92) begin
        seq.insert(seq.size(), {5'b11110, 3'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
        seq.insert(seq.size(), {2'b10, 6'($urandom)});
      end else begin
        seq.insert(seq.size(), 8'($urandom));
      end
    end
    if (seq.size() > 0 && $urandom_range(0, 9) == 0) void'(seq.pop_back());
    term = (seq.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (seq[i]) begin
      if (i > 0 && $urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0, 1'b0);
      send_word(seq[i], 1'b1, i == 0, !term && i == seq.size() - 1);
    end
    if (term) send_word(8'($urandom), 1'b0, seq.size() == 0, 1'b1);
  endtask

  task automatic test_random_strings();
    while (words_sent < 290) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      send_random_string();
    end
  endtask

  task automatic test_noise();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (40) begin
      send_word(8'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_stall();
    test_random_strings();
    test_noise();
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_to_json_string_escaper verification clean");
    end else begin
      $display("utf8_to_json_string_escaper verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/u2j_pkg.sv
sv/u2j_front.sv
sv/u2j_queue.sv
sv/u2j_back.sv
sv/utf8_to_json_string_escaper.sv
test/utf8_to_json_string_escaper_tb.sv
